FILE: sv/rpd_pkg.sv
package rpd_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanW       = 2;
  localparam int unsigned TimeW       = 15;
  localparam int unsigned WidthW      = 16;
  localparam int unsigned ValueW      = 16;
  localparam int unsigned ThrOutW     = 15;
  localparam int unsigned TimeoutW    = 10;
  localparam int unsigned EdgeW       = 2;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 15;

  localparam int unsigned InDataW     = 24;
  localparam int unsigned InUserW     = 1;
  localparam int unsigned OutDataW    = 72;

  localparam logic [WidthW-1:0]   WrapSpan   = 16'h8000;
  localparam logic [TimeoutW-1:0] TimeoutSat = 10'd1000;
  localparam logic [EdgeW-1:0]    PairEdges  = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AILERON_CENTER    = 3'd0,
    CFG_ELEVATOR_CENTER   = 3'd1,
    CFG_RUDDER_CENTER     = 3'd2,
    CFG_THROTTLE_BOTTOM   = 3'd3,
    CFG_GESTURE_THRESHOLD = 3'd4,
    CFG_TIMEOUT_LIMIT     = 3'd5
  } cfg_idx_e;

  typedef enum logic [ChanW-1:0] {
    CH_AILERON  = 2'd0,
    CH_ELEVATOR = 2'd1,
    CH_THROTTLE = 2'd2,
    CH_RUDDER   = 2'd3
  } chan_e;

  typedef enum logic {
    MODE_CAPTURE = 1'b0,
    MODE_TICK    = 1'b1
  } mode_e;

  localparam int unsigned OutLinkBit = 63;
  localparam int unsigned OutCalBit  = 64;
  localparam int unsigned OutArmBit  = 65;

endpackage

FILE: sv/rc_pwm_pulse_decoder.sv
// Four-channel RC receiver PWM decoder.
// The slave stream carries one event per item: tuser[0] selects an edge
// capture (0) or a timer tick (1); tdata holds channel, capture time and
// pin level. Every accepted item yields exactly one item on the master
// stream with the four stick values and the link, calibrate and arm flags.
// The configuration channel writes the centers, throttle bottom, gesture
// threshold and timeout limit; it is always ready and must be used only
// while the block is idle.
// An item is registered at the input, then decoded by one pass of logic
// straight into the state registers that drive the master tdata. One item
// per cycle is sustained while the receiver keeps tready high.
// When the receiver stalls, the result holds and the input register still
// takes one more item; further items wait on tready.
// Reset clears all channel captures and values, sets the timeout count to
// its saturation value with the link reported down, and loads the default
// register values.
module rc_pwm_pulse_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // channel[1:0], capture_time[16:2], pin_high[17], zero[23:18]
  input  logic [rpd_pkg::InDataW-1:0]   s_axis_tdata_i,
  // mode[0]
  input  logic [rpd_pkg::InUserW-1:0]   s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // aileron[15:0], elevator[31:16], throttle[46:32], rudder[62:47],
  // link_up[63], calibrate_request[64], arm_request[65], zero[71:66]
  output logic [rpd_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import rpd_pkg::*;

  logic [TimeW-1:0]    ail_ctr_q, ele_ctr_q, rud_ctr_q, thr_bot_q, gest_q;
  logic [TimeoutW-1:0] tlim_q;

  logic               in_valid_q;
  mode_e              in_mode_q;
  logic [ChanW-1:0]   in_ch_q;
  logic [TimeW-1:0]   in_time_q;
  logic               in_high_q;

  logic               out_valid_q, out_valid_d;
  logic               adv;

  logic [EdgeW-1:0]   edge_q [NumChannels], edge_d [NumChannels];
  logic [TimeW-1:0]   rise_q [NumChannels], rise_d [NumChannels];
  logic [TimeW-1:0]   fall_q [NumChannels], fall_d [NumChannels];
  logic [WidthW-1:0]  width_q [NumChannels], width_d [NumChannels];
  logic [ValueW-1:0]  ail_q, ail_d, ele_q, ele_d, thr_q, thr_d, rud_q, rud_d;
  logic [TimeoutW-1:0] tc_q, tc_d;
  logic               link_q, link_d, cal_q, cal_d, arm_q, arm_d;

  logic [EdgeW-1:0]   ec_new;
  logic [TimeW-1:0]   f_sel, r_sel;
  logic [WidthW-1:0]  w_sel, diff;
  logic [TimeoutW-1:0] tc_inc;
  logic signed [16:0] thr_p, thr_n, ail_s, ele_s, rud_s;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ail_ctr_q <= 15'd6000;
      ele_ctr_q <= 15'd6000;
      rud_ctr_q <= 15'd6000;
      thr_bot_q <= 15'd4000;
      gest_q    <= 15'd1000;
      tlim_q    <= 10'd50;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AILERON_CENTER:    ail_ctr_q <= cfg_data_i;
        CFG_ELEVATOR_CENTER:   ele_ctr_q <= cfg_data_i;
        CFG_RUDDER_CENTER:     rud_ctr_q <= cfg_data_i;
        CFG_THROTTLE_BOTTOM:   thr_bot_q <= cfg_data_i;
        CFG_GESTURE_THRESHOLD: gest_q    <= cfg_data_i;
        CFG_TIMEOUT_LIMIT:     tlim_q    <= cfg_data_i[TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;
  assign m_axis_tvalid_o = out_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_mode_q <= mode_e'(s_axis_tuser_i[0]);
      in_ch_q   <= s_axis_tdata_i[1:0];
      in_time_q <= s_axis_tdata_i[16:2];
      in_high_q <= s_axis_tdata_i[17];
    end
  end

  always_comb begin
    edge_d  = edge_q;
    rise_d  = rise_q;
    fall_d  = fall_q;
    width_d = width_q;
    ail_d   = ail_q;
    ele_d   = ele_q;
    thr_d   = thr_q;
    rud_d   = rud_q;
    tc_d    = tc_q;
    link_d  = link_q;
    cal_d   = cal_q;
    arm_d   = arm_q;

    ec_new = (edge_q[in_ch_q] < PairEdges) ? edge_q[in_ch_q] + 2'd1 : edge_q[in_ch_q];
    f_sel  = in_time_q;
    r_sel  = rise_q[in_ch_q];
    diff   = {1'b0, f_sel} - {1'b0, r_sel};
    w_sel  = width_q[in_ch_q];
    if (ec_new >= PairEdges) begin
      w_sel = (f_sel > r_sel) ? diff : diff + WrapSpan;
    end
    tc_inc = (tc_q < TimeoutSat) ? tc_q + 10'd1 : tc_q;

    thr_p = $signed({2'b00, gest_q});
    thr_n = -thr_p;

    if (in_mode_q == MODE_CAPTURE) begin
      tc_d             = '0;
      edge_d[in_ch_q]  = ec_new;
      if (in_high_q) begin
        rise_d[in_ch_q] = in_time_q;
      end else begin
        fall_d[in_ch_q]  = in_time_q;
        width_d[in_ch_q] = w_sel;
        case (chan_e'(in_ch_q))
          CH_AILERON:  ail_d = w_sel - {1'b0, ail_ctr_q};
          CH_ELEVATOR: ele_d = w_sel - {1'b0, ele_ctr_q};
          CH_THROTTLE: thr_d = (w_sel > {1'b0, thr_bot_q}) ? w_sel - {1'b0, thr_bot_q} : '0;
          CH_RUDDER:   rud_d = w_sel - {1'b0, rud_ctr_q};
          default: ;
        endcase
      end
    end else begin
      tc_d   = tc_inc;
      link_d = (tc_inc <= tlim_q);
      if (tc_inc > tlim_q) begin
        for (int i = 0; i < NumChannels; i++) begin
          edge_d[i]  = '0;
          rise_d[i]  = '0;
          fall_d[i]  = '0;
          width_d[i] = '0;
        end
      end
    end

    ail_s = $signed({ail_d[15], ail_d});
    ele_s = $signed({ele_d[15], ele_d});
    rud_s = $signed({rud_d[15], rud_d});
    if (in_mode_q == MODE_CAPTURE && !in_high_q && thr_d == '0 && ele_s < thr_n) begin
      if (ail_s > thr_p && rud_s < thr_n) begin
        cal_d = 1'b1;
      end
      if (ail_s < thr_n && rud_s > thr_p) begin
        arm_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        edge_q[i]  <= '0;
        rise_q[i]  <= '0;
        fall_q[i]  <= '0;
        width_q[i] <= '0;
      end
      ail_q  <= '0;
      ele_q  <= '0;
      thr_q  <= '0;
      rud_q  <= '0;
      tc_q   <= TimeoutSat;
      link_q <= 1'b0;
      cal_q  <= 1'b0;
      arm_q  <= 1'b0;
    end else if (adv) begin
      edge_q  <= edge_d;
      rise_q  <= rise_d;
      fall_q  <= fall_d;
      width_q <= width_d;
      ail_q   <= ail_d;
      ele_q   <= ele_d;
      thr_q   <= thr_d;
      rud_q   <= rud_d;
      tc_q    <= tc_d;
      link_q  <= link_d;
      cal_q   <= cal_d;
      arm_q   <= arm_d;
    end
  end

  assign m_axis_tdata_o = {6'b0, arm_q, cal_q, link_q, rud_q, thr_q[ThrOutW-1:0], ele_q, ail_q};

endmodule

FILE: sv/rpd_checker.sv
module rpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [rpd_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import rpd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result item changed");

  a_cal_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tdata_o[OutCalBit] |=> m_axis_tdata_o[OutCalBit])
    else $error("calibrate request cleared without reset");

  a_arm_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tdata_o[OutArmBit] |=> m_axis_tdata_o[OutArmBit])
    else $error("arm request cleared without reset");

  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && !(s_axis_tvalid_i && s_axis_tready_o) |=> $stable(m_axis_tdata_o)
      || m_axis_tvalid_o)
    else $error("result data changed with no item in flight");

endmodule

bind rc_pwm_pulse_decoder rpd_checker u_rpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: dv/rc_pwm_pulse_decoder_tb.sv
`timescale 1ns / 1ps

module rc_pwm_pulse_decoder_tb;
  import rpd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned HoldAfter  = 350;
  localparam int unsigned PhaseItems = 190;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam logic [TimeW-1:0]   TimeMax    = 15'h7fff;

  typedef enum int {
    RX_OPEN,
    RX_MOSTLY,
    RX_SPARSE,
    RX_PULSED
  } rx_pattern_e;

  typedef struct packed {
    logic [OutDataW-67:0] pad;
    logic                 arm;
    logic                 cal;
    logic                 link;
    logic [ValueW-1:0]    rudder;
    logic [ThrOutW-1:0]   throttle;
    logic [ValueW-1:0]    elevator;
    logic [ValueW-1:0]    aileron;
  } stick_out_t;

  class stick_tracker;
    logic [CfgDataW-1:0] ail_ctr, ele_ctr, rud_ctr, thr_bot, gest_thr;
    logic [TimeoutW-1:0] to_limit;
    logic [EdgeW-1:0]    edges  [NumChannels];
    logic [TimeW-1:0]    rise_t [NumChannels];
    logic [TimeW-1:0]    fall_t [NumChannels];
    logic [WidthW-1:0]   pulse  [NumChannels];
    logic [ValueW-1:0]   ail_v, ele_v, thr_v, rud_v;
    logic [TimeoutW-1:0] to_cnt;
    logic                link, cal, arm;
    stick_out_t          expected_sticks [$];
    int                  errors;
    int                  checked;

    function new();
      ail_ctr  = 15'd6000;
      ele_ctr  = 15'd6000;
      rud_ctr  = 15'd6000;
      thr_bot  = 15'd4000;
      gest_thr = 15'd1000;
      to_limit = 10'd50;
      clear_channels();
      ail_v    = '0;
      ele_v    = '0;
      thr_v    = '0;
      rud_v    = '0;
      to_cnt   = TimeoutSat;
      link     = 1'b0;
      cal      = 1'b0;
      arm      = 1'b0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void clear_channels();
      for (int i = 0; i < NumChannels; i++) begin
        edges[i]  = '0;
        rise_t[i] = '0;
        fall_t[i] = '0;
        pulse[i]  = '0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_AILERON_CENTER:    ail_ctr  = data;
        CFG_ELEVATOR_CENTER:   ele_ctr  = data;
        CFG_RUDDER_CENTER:     rud_ctr  = data;
        CFG_THROTTLE_BOTTOM:   thr_bot  = data;
        CFG_GESTURE_THRESHOLD: gest_thr = data;
        CFG_TIMEOUT_LIMIT:     to_limit = data[TimeoutW-1:0];
        default: ;
      endcase
    endfunction

    function void update_stick(logic [ChanW-1:0] ch);
      logic [WidthW-1:0] w;
      int t, a, e, r;
      w = pulse[ch];
      t = gest_thr;
      case (ch)
        CH_AILERON:  ail_v = w - {1'b0, ail_ctr};
        CH_ELEVATOR: ele_v = w - {1'b0, ele_ctr};
        CH_THROTTLE: thr_v = (w > {1'b0, thr_bot}) ? w - {1'b0, thr_bot} : '0;
        default:     rud_v = w - {1'b0, rud_ctr};
      endcase
      a = $signed(ail_v);
      e = $signed(ele_v);
      r = $signed(rud_v);
      if (thr_v == '0 && e < -t) begin
        if (a > t && r < -t) cal = 1'b1;
        if (a < -t && r > t) arm = 1'b1;
      end
    endfunction

    function void note_event(mode_e mode, logic [ChanW-1:0] ch, logic [TimeW-1:0] tcap,
                             logic hi);
      stick_out_t o;
      if (mode == MODE_CAPTURE) begin
        to_cnt = '0;
        if (edges[ch] < PairEdges) edges[ch]++;
        if (hi) begin
          rise_t[ch] = tcap;
        end else begin
          fall_t[ch] = tcap;
          if (edges[ch] >= PairEdges) begin
            pulse[ch] = (fall_t[ch] > rise_t[ch]) ? {1'b0, fall_t[ch]} - {1'b0, rise_t[ch]}
                                                  : {1'b0, fall_t[ch]} + WrapSpan
                                                    - {1'b0, rise_t[ch]};
          end
          update_stick(ch);
        end
      end else begin
        if (to_cnt < TimeoutSat) to_cnt++;
        if (to_cnt > to_limit) clear_channels();
        link = (to_cnt <= to_limit);
      end
      o          = '0;
      o.aileron  = ail_v;
      o.elevator = ele_v;
      o.throttle = thr_v[ThrOutW-1:0];
      o.rudder   = rud_v;
      o.link     = link;
      o.cal      = cal;
      o.arm      = arm;
      expected_sticks.push_back(o);
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [ValueW-1:0] got, logic [ValueW-1:0] want);
      if (got !== want) begin
        flag_mismatch($sformatf("result %0d %s: got %h, expected %h", checked, name, got,
                                want));
      end
    endtask

    task check_sticks(logic [OutDataW-1:0] data);
      stick_out_t got, want;
      got = data;
      if (expected_sticks.size() == 0) begin
        flag_mismatch($sformatf("result %h arrived with no event pending", data));
        return;
      end
      want = expected_sticks.pop_front();
      compare_field("aileron", got.aileron, want.aileron);
      compare_field("elevator", got.elevator, want.elevator);
      compare_field("throttle", got.throttle, want.throttle);
      compare_field("rudder", got.rudder, want.rudder);
      compare_field("link_up", got.link, want.link);
      compare_field("calibrate_request", got.cal, want.cal);
      compare_field("arm_request", got.arm, want.arm);
      compare_field("padding", got.pad, want.pad);
      checked++;
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [InUserW-1:0]  s_tuser = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  stick_tracker sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int cycles = 0;

  rc_pwm_pulse_decoder u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_sticks(m_tdata);
  end

  // The receiver changes its stall pattern now and then, and once holds off for a
  // long stretch so that the block backs up into its input.
  initial begin
    rx_pattern_e pattern;
    int pattern_left, hold_left;
    bit held;
    pattern      = RX_OPEN;
    pattern_left = 0;
    hold_left    = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sb.checked >= HoldAfter) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = rx_pattern_e'($urandom_range(0, 3));
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern)
          RX_OPEN:   m_ready <= 1'b1;
          RX_MOSTLY: m_ready <= ($urandom_range(0, 9) < 7);
          RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
          default:   m_ready <= ((pattern_left / 8) % 2 == 0);
        endcase
      end
    end
  end

  task send_event(mode_e mode, logic [ChanW-1:0] ch, logic [TimeW-1:0] tcap, logic hi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    s_valid <= 1'b1;
    s_tdata <= {{(InDataW - 18){1'b0}}, hi, tcap, ch};
    s_tuser <= mode;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sb.note_event(mode, ch, tcap, hi);
    items_sent++;
    burst_left--;
  endtask

  task send_tick();
    send_event(MODE_TICK, ChanW'($urandom_range(0, 3)), TimeW'($urandom_range(0, 32767)),
               1'($urandom_range(0, 1)));
  endtask

  task drain_block();
    if (s_valid) begin
      @(negedge clk);
      s_valid <= 1'b0;
    end
    while (sb.expected_sticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    drain_block();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task set_all(logic [CfgDataW-1:0] ail, logic [CfgDataW-1:0] ele, logic [CfgDataW-1:0] rud,
               logic [CfgDataW-1:0] bot, logic [CfgDataW-1:0] thr,
               logic [CfgDataW-1:0] limit);
    write_reg(CFG_AILERON_CENTER, ail);
    write_reg(CFG_ELEVATOR_CENTER, ele);
    write_reg(CFG_RUDDER_CENTER, rud);
    write_reg(CFG_THROTTLE_BOTTOM, bot);
    write_reg(CFG_GESTURE_THRESHOLD, thr);
    write_reg(CFG_TIMEOUT_LIMIT, limit);
  endtask

  function automatic int pick_width(logic [ChanW-1:0] ch);
    int base, span, r;
    case (ch)
      CH_AILERON:  base = sb.ail_ctr;
      CH_ELEVATOR: base = sb.ele_ctr;
      CH_THROTTLE: base = sb.thr_bot;
      default:     base = sb.rud_ctr;
    endcase
    span = 2 * int'(sb.gest_thr) + 500;
    if (span > 12000) span = 12000;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 32767);
    if (ch == CH_THROTTLE && r < 5) return base - int'($urandom_range(0, 600));
    return base + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // One receiver frame: a rising and a falling edge per channel, with a channel
  // skipped now and then and a stray tick between the edges.
  task send_frame();
    logic [TimeW-1:0] rise;
    int w;
    for (int i = 0; i < NumChannels; i++) begin
      if ($urandom_range(0, 9) == 0) continue;
      w    = pick_width(ChanW'(i));
      rise = TimeW'($urandom_range(0, 32767));
      send_event(MODE_CAPTURE, ChanW'(i), rise, 1'b1);
      if ($urandom_range(0, 7) == 0) send_tick();
      send_event(MODE_CAPTURE, ChanW'(i), rise + w[TimeW-1:0], 1'b0);
    end
    repeat ($urandom_range(0, 2)) send_tick();
  endtask

  task run_random(int count);
    int stop, pick, n;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 82) begin
        n = int'(sb.to_limit) + $urandom_range(1, 4);
        if (n > 80) n = 80;
        repeat (n) send_tick();
      end else begin
        send_event(mode_e'(1'($urandom_range(0, 1))), ChanW'($urandom_range(0, 3)),
                   TimeW'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The count starts saturated, so a limit above saturation brings the link up
    // at once, while a limit just below it keeps the link down.
    write_reg(CFG_TIMEOUT_LIMIT, TimeMax);
    send_tick();
    write_reg(CFG_TIMEOUT_LIMIT, 15'd999);
    send_tick();
    write_reg(CFG_TIMEOUT_LIMIT, 15'd50);

    send_event(MODE_CAPTURE, CH_AILERON, 15'd0, 1'b0);
    send_event(MODE_CAPTURE, CH_AILERON, TimeMax, 1'b1);
    send_event(MODE_CAPTURE, CH_AILERON, 15'd100, 1'b0);
    send_event(MODE_CAPTURE, CH_ELEVATOR, 15'd500, 1'b1);
    send_event(MODE_CAPTURE, CH_ELEVATOR, 15'd500, 1'b0);
    send_tick();

    send_event(MODE_CAPTURE, CH_THROTTLE, 15'd1000, 1'b1);
    send_event(MODE_CAPTURE, CH_THROTTLE, 15'd4000, 1'b0);
    send_event(MODE_CAPTURE, CH_ELEVATOR, 15'd0, 1'b1);
    send_event(MODE_CAPTURE, CH_ELEVATOR, 15'd4000, 1'b0);
    send_event(MODE_CAPTURE, CH_AILERON, 15'd10000, 1'b1);
    send_event(MODE_CAPTURE, CH_AILERON, 15'd18000, 1'b0);
    send_event(MODE_CAPTURE, CH_RUDDER, 15'd20000, 1'b1);
    send_event(MODE_CAPTURE, CH_RUDDER, 15'd24000, 1'b0);
    send_event(MODE_CAPTURE, CH_AILERON, 15'd0, 1'b1);
    send_event(MODE_CAPTURE, CH_AILERON, 15'd4000, 1'b0);
    send_event(MODE_CAPTURE, CH_RUDDER, 15'd0, 1'b1);
    send_event(MODE_CAPTURE, CH_RUDDER, 15'd8000, 1'b0);

    write_reg(CFG_THROTTLE_BOTTOM, 15'd0);
    send_event(MODE_CAPTURE, CH_THROTTLE, 15'd300, 1'b1);
    send_event(MODE_CAPTURE, CH_THROTTLE, 15'd300, 1'b0);
    send_tick();

    set_all(15'd6000, 15'd6000, 15'd6000, 15'd4000, 15'd1000, 15'd50);
    run_random(PhaseItems);
    write_reg(CfgSpareLo, 15'h1234);
    write_reg(CfgSpareHi, TimeMax);
    set_all(TimeMax, TimeMax, TimeMax, TimeMax, TimeMax, 15'd999);
    run_random(PhaseItems);
    set_all(15'd0, 15'd0, 15'd0, 15'd1, 15'd0, 15'd0);
    run_random(PhaseItems);
    set_all(CfgDataW'($urandom_range(0, 32767)), CfgDataW'($urandom_range(0, 32767)),
            CfgDataW'($urandom_range(0, 32767)), CfgDataW'($urandom_range(1, 32767)),
            CfgDataW'($urandom_range(0, 32767)), CfgDataW'($urandom_range(0, 32767)));
    run_random(PhaseItems);
    set_all(CfgDataW'($urandom_range(4000, 8000)), CfgDataW'($urandom_range(4000, 8000)),
            CfgDataW'($urandom_range(4000, 8000)), CfgDataW'($urandom_range(2000, 6000)),
            CfgDataW'($urandom_range(0, 1500)), CfgDataW'($urandom_range(1, 30)));
    run_random(PhaseItems);
    set_all(15'd6000, 15'd6000, 15'd6000, 15'd0, 15'd800, 15'd20);
    run_random(PhaseItems);

    drain_block();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_sticks.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
